[sv/rlms_pkg.sv]
// ----------------------------------------------------------------------------
// rlms_pkg: shared types and constants of the raster local minimum sum block
// Field widths, register codes and the control bundle of the window cells.
// ----------------------------------------------------------------------------
package rlms_pkg;

    localparam int FW_W        = 8;      // frame_width register
    localparam int FH_W        = 13;     // frame_height register
    localparam int ROW_W       = 12;     // row index
    localparam int SUM_W       = 24;     // risk_sum field
    localparam int COUNT_W     = 20;     // low_count field
    localparam int CFG_DATA_W  = 13;     // widest configuration register
    localparam int CFG_INDEX_W = 1;

    localparam logic [FH_W-1:0]    HEIGHT_MAX         = 13'd4096;
    localparam logic [FW_W-1:0]    FRAME_WIDTH_RESET  = 8'd100;
    localparam logic [FH_W-1:0]    FRAME_HEIGHT_RESET = 13'd100;
    localparam logic [SUM_W-1:0]   SUM_MAX            = 24'hFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = 20'hF_FFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // Control of the window cells: shift on every accepted item, and empty
    // the window when the item closes a row.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

[sv/rlms_ram.sv]
// ----------------------------------------------------------------------------
// rlms_ram: generic line store
// One write port, two read ports with registered read data. A read of the
// address being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module rlms_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr_a)) begin
            r_rdata_a <= i_wdata;
        end else begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_we && (i_waddr == i_raddr_b)) begin
            r_rdata_b <= i_wdata;
        end else begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[sv/rlms_cell.sv]
// ----------------------------------------------------------------------------
// rlms_cell: one column of the neighbourhood window
// Holds the pixel above and the pixel of the current row for one column
// behind the current one, and hands them on to the next cell per item.
// ----------------------------------------------------------------------------
module rlms_cell #(
    parameter int VALUE_BITS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rlms_pkg::t_cell_ctrl    i_ctrl,
    input  logic                    i_valid,
    input  logic [VALUE_BITS-1:0]   i_above,
    input  logic [VALUE_BITS-1:0]   i_cur,
    output logic                    o_valid,
    output logic [VALUE_BITS-1:0]   o_above,
    output logic [VALUE_BITS-1:0]   o_cur
);

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_above;
    logic [VALUE_BITS-1:0] r_cur;

    // The valid bit says that this column exists in the current row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_valid && !i_ctrl.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_above <= i_above;
            r_cur   <= i_cur;
        end
    end

    assign o_valid = r_valid;
    assign o_above = r_above;
    assign o_cur   = r_cur;

endmodule

[sv/rlms_judge.sv]
// ----------------------------------------------------------------------------
// rlms_judge: strict local minimum test
// A pixel is low when it lies strictly below every neighbour that exists.
// ----------------------------------------------------------------------------
module rlms_judge #(
    parameter int VALUE_BITS = 4
) (
    input  logic                  i_enable,
    input  logic [VALUE_BITS-1:0] i_center,
    input  logic                  i_has_r,
    input  logic [VALUE_BITS-1:0] i_r,
    input  logic                  i_has_l,
    input  logic [VALUE_BITS-1:0] i_l,
    input  logic                  i_has_d,
    input  logic [VALUE_BITS-1:0] i_d,
    input  logic                  i_has_u,
    input  logic [VALUE_BITS-1:0] i_u,
    output logic                  o_low
);

    always_comb begin
        o_low = i_enable
             && !(i_has_r && (i_r <= i_center))
             && !(i_has_l && (i_l <= i_center))
             && !(i_has_d && (i_d <= i_center))
             && !(i_has_u && (i_u <= i_center));
    end

endmodule

[sv/raster_local_minimum_sum.sv]
// ----------------------------------------------------------------------------
// raster_local_minimum_sum: sum and count of four-neighbour low points
// Pixels arrive in row-major order. Two line stores, alternating by row,
// and a two-cell window give each pixel its neighbours; one result item
// per frame carries the risk sum and the number of low points.
//
//   channel   direction  handshake                payload
//   -------   ---------  -----------------------  -----------------------------
//   in        input      i_in_valid / o_in_stall  i_height_value
//   out       output     o_out_valid / i_out_stall o_risk_sum, o_low_count
//   cfg       input      i_cfg_we (no wait)       i_cfg_index, i_cfg_data
//
// One item is taken per clock unless the input stalls; the line stores are
// read ahead at the column of the next item, so their registered read sets
// no extra wait. The result of the frame's last pixel appears in the output
// register on the following cycle. The input stalls only when a result
// still waits in that register and the next item would produce another one.
// Reset is synchronous; the line stores hold no reset and need no clearing.
// ----------------------------------------------------------------------------
module raster_local_minimum_sum #(
    parameter int MAX_WIDTH  = 128,
    parameter int VALUE_BITS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [VALUE_BITS-1:0]             i_height_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rlms_pkg::SUM_W-1:0]        o_risk_sum,
    output logic [rlms_pkg::COUNT_W-1:0]      o_low_count,
    input  logic                              i_cfg_we,
    input  logic [rlms_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rlms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = (CW + 1 > rlms_pkg::FW_W) ? CW + 1 : rlms_pkg::FW_W;
    localparam int INC_W = VALUE_BITS + 2;
    localparam int SW1   = rlms_pkg::SUM_W + 1;
    localparam int CW1   = rlms_pkg::COUNT_W + 1;

    // Configuration and control state
    logic [rlms_pkg::FW_W-1:0]    r_fw;
    logic [rlms_pkg::FH_W-1:0]    r_fh;
    logic [CW-1:0]                r_col;
    logic [CW-1:0]                n_col;
    logic [rlms_pkg::ROW_W-1:0]   r_row;
    logic [rlms_pkg::ROW_W-1:0]   n_row;
    logic [rlms_pkg::SUM_W-1:0]   r_acc;
    logic [rlms_pkg::COUNT_W-1:0] r_cnt;
    logic                         r_out_valid;
    logic [rlms_pkg::SUM_W-1:0]   r_out_sum;
    logic [rlms_pkg::COUNT_W-1:0] r_out_cnt;

    logic                   accept_in;
    logic [CW:0]            col_inc;
    logic [rlms_pkg::FH_W-1:0] row_inc;
    logic                   last_col;
    logic                   last_row;
    logic                   is_last;
    logic                   row_ge1;
    logic                   row_ge2;

    // Line store ports
    logic [CW-1:0]          rd_addr_a;
    logic [CW-1:0]          rd_addr_b;
    logic [VALUE_BITS-1:0]  ram_a [2];
    logic [VALUE_BITS-1:0]  ram_b [2];
    logic [VALUE_BITS-1:0]  above_c;
    logic [VALUE_BITS-1:0]  above_r;
    logic [VALUE_BITS-1:0]  cur_c;

    // Window cells
    rlms_pkg::t_cell_ctrl   cell_ctrl;
    logic                   c0_valid;
    logic [VALUE_BITS-1:0]  c0_above;
    logic [VALUE_BITS-1:0]  c0_cur;
    logic                   c1_valid;
    logic [VALUE_BITS-1:0]  c1_cur;

    // Judgements and accumulation
    logic                   low_up;
    logic                   low_left;
    logic                   low_here;
    logic [INC_W-1:0]       inc_sum;
    logic [1:0]             inc_cnt;
    logic [SW1-1:0]         sum_wide;
    logic [CW1-1:0]         cnt_wide;
    logic [rlms_pkg::SUM_W-1:0]   sum_sat;
    logic [rlms_pkg::COUNT_W-1:0] cnt_sat;

    // ------------------------------------------------------------------
    // Position in the frame. A zero register acts as one, and the upper
    // bounds clamp, which the comparisons below give without a special path.
    // ------------------------------------------------------------------
    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;
    assign last_col = (WW'(col_inc) >= WW'(r_fw))
                   || (col_inc >= (CW + 1)'(MAX_WIDTH));
    assign last_row = (row_inc >= r_fh) || (row_inc >= rlms_pkg::HEIGHT_MAX);
    assign is_last  = last_col && last_row;
    assign row_ge1  = (r_row != '0);
    assign row_ge2  = |r_row[rlms_pkg::ROW_W-1:1];

    assign o_in_stall = r_out_valid && i_out_stall && is_last;
    assign accept_in  = i_in_valid && !o_in_stall;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept_in) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : rlms_pkg::ROW_W'(row_inc);
            end else begin
                n_col = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= rlms_pkg::FRAME_WIDTH_RESET;
            r_fh <= rlms_pkg::FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (rlms_pkg::t_cfg_index'(i_cfg_index))
                rlms_pkg::CFG_FRAME_WIDTH: begin
                    r_fw <= i_cfg_data[rlms_pkg::FW_W-1:0];
                end
                rlms_pkg::CFG_FRAME_HEIGHT: begin
                    r_fh <= i_cfg_data[rlms_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Line stores: store k holds the rows whose index has parity k. Both
    // are read at the next item's column and the one to its right.
    // ------------------------------------------------------------------
    assign rd_addr_a = n_col;
    assign rd_addr_b = (n_col == CW'(MAX_WIDTH - 1)) ? '0 : n_col + 1'b1;

    for (genvar k = 0; k < 2; k++) begin : g_store
        rlms_ram #(
            .WIDTH (VALUE_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_store (
            .i_clk     (i_clk),
            .i_we      (accept_in && (r_row[0] == 1'(k))),
            .i_waddr   (r_col),
            .i_wdata   (i_height_value),
            .i_raddr_a (rd_addr_a),
            .i_raddr_b (rd_addr_b),
            .o_rdata_a (ram_a[k]),
            .o_rdata_b (ram_b[k])
        );
    end

    // The store of the current row still holds the row two above.
    assign above_c = r_row[0] ? ram_a[0] : ram_a[1];
    assign above_r = r_row[0] ? ram_b[0] : ram_b[1];
    assign cur_c   = r_row[0] ? ram_a[1] : ram_a[0];

    // ------------------------------------------------------------------
    // Window: cell 0 holds column c-1, cell 1 holds column c-2.
    // ------------------------------------------------------------------
    assign cell_ctrl.shift = accept_in;
    assign cell_ctrl.clear = accept_in && last_col;

    rlms_cell #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cell0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cell_ctrl),
        .i_valid (1'b1),
        .i_above (above_c),
        .i_cur   (i_height_value),
        .o_valid (c0_valid),
        .o_above (c0_above),
        .o_cur   (c0_cur)
    );

    rlms_cell #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cell_ctrl),
        .i_valid (c0_valid),
        .i_above (c0_above),
        .i_cur   (c0_cur),
        .o_valid (c1_valid),
        .o_above (),
        .o_cur   (c1_cur)
    );

    // ------------------------------------------------------------------
    // The pixel above is complete once the pixel below it arrives. In the
    // last row the left pixel is complete when its right neighbour comes,
    // and the frame's last pixel is judged at once.
    // ------------------------------------------------------------------
    rlms_judge #(
        .VALUE_BITS (VALUE_BITS)
    ) u_judge_up (
        .i_enable (row_ge1),
        .i_center (above_c),
        .i_has_r  (!last_col),
        .i_r      (above_r),
        .i_has_l  (c0_valid),
        .i_l      (c0_above),
        .i_has_d  (1'b1),
        .i_d      (i_height_value),
        .i_has_u  (row_ge2),
        .i_u      (cur_c),
        .o_low    (low_up)
    );

    rlms_judge #(
        .VALUE_BITS (VALUE_BITS)
    ) u_judge_left (
        .i_enable (last_row && c0_valid),
        .i_center (c0_cur),
        .i_has_r  (1'b1),
        .i_r      (i_height_value),
        .i_has_l  (c1_valid),
        .i_l      (c1_cur),
        .i_has_d  (1'b0),
        .i_d      (i_height_value),
        .i_has_u  (row_ge1),
        .i_u      (c0_above),
        .o_low    (low_left)
    );

    rlms_judge #(
        .VALUE_BITS (VALUE_BITS)
    ) u_judge_here (
        .i_enable (is_last),
        .i_center (i_height_value),
        .i_has_r  (1'b0),
        .i_r      (c0_cur),
        .i_has_l  (c0_valid),
        .i_l      (c0_cur),
        .i_has_d  (1'b0),
        .i_d      (c0_cur),
        .i_has_u  (row_ge1),
        .i_u      (above_c),
        .o_low    (low_here)
    );

    always_comb begin
        inc_sum = '0;
        if (low_up) begin
            inc_sum = inc_sum + INC_W'(above_c) + 1'b1;
        end
        if (low_left) begin
            inc_sum = inc_sum + INC_W'(c0_cur) + 1'b1;
        end
        if (low_here) begin
            inc_sum = inc_sum + INC_W'(i_height_value) + 1'b1;
        end
        inc_cnt = 2'(low_up) + 2'(low_left) + 2'(low_here);
    end

    // Saturating once after the whole increment equals saturating per add.
    assign sum_wide = SW1'(r_acc) + SW1'(inc_sum);
    assign cnt_wide = CW1'(r_cnt) + CW1'(inc_cnt);
    assign sum_sat  = (sum_wide > SW1'(rlms_pkg::SUM_MAX))
                    ? rlms_pkg::SUM_MAX : sum_wide[rlms_pkg::SUM_W-1:0];
    assign cnt_sat  = (cnt_wide > CW1'(rlms_pkg::COUNT_MAX))
                    ? rlms_pkg::COUNT_MAX : cnt_wide[rlms_pkg::COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (accept_in) begin
            if (is_last) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= sum_sat;
                r_cnt <= cnt_sat;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept_in && is_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in && is_last) begin
            r_out_sum <= sum_sat;
            r_out_cnt <= cnt_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_risk_sum  = r_out_sum;
    assign o_low_count = r_out_cnt;

endmodule

[sv/rlms_checker.sv]
// ----------------------------------------------------------------------------
// rlms_checker: port-level checks of the raster local minimum sum block
// Watches the handshakes and the result item over time.
// ----------------------------------------------------------------------------
module rlms_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic [rlms_pkg::SUM_W-1:0]   o_risk_sum,
    input  logic [rlms_pkg::COUNT_W-1:0] o_low_count
);

    localparam int PAD_W = rlms_pkg::SUM_W - rlms_pkg::COUNT_W;

    // A waiting result is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item withdrawn while stalled");

    // A waiting result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_risk_sum) && $stable(o_low_count))
        else $error("result item changed while stalled");

    // The input is only held back by a result that cannot leave.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with a free output register");

    // Each low point adds at least one to the sum.
    a_sum_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({{PAD_W{1'b0}}, o_low_count} <= o_risk_sum))
        else $error("low point count exceeds risk sum");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item present after reset");

endmodule

bind raster_local_minimum_sum rlms_checker u_rlms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_risk_sum  (o_risk_sum),
    .o_low_count (o_low_count)
);

[bench/tb_raster_local_minimum_sum.sv]
// ----------------------------------------------------------------------------
// tb_raster_local_minimum_sum: self-checking bench of the low point summer
// Streams rasters of many shapes through the block, one pixel per item, and
// checks each frame's risk sum and low point count against a predictor that
// models the two line stores. A short scripted part covers the extremes,
// the clamped register values and register changes inside a frame. Random
// frames follow, with idle cycles on both sides and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_raster_local_minimum_sum;

    localparam int LINE_DEPTH    = 128;
    localparam int PIX_BITS      = 4;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SCRIPT_LEN    = 35;

    typedef struct packed {
        logic [rlms_pkg::SUM_W-1:0]   risk_sum;
        logic [rlms_pkg::COUNT_W-1:0] low_count;
    } t_frame_total;

    typedef enum logic {ROW_REG, ROW_PIXEL} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        rlms_pkg::t_cfg_index            sel;
        logic [rlms_pkg::CFG_DATA_W-1:0] data;
        logic [PIX_BITS-1:0]             pix;
        logic                            typed;
        t_frame_total                    total;
    } t_script_row;

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             i_in_valid     = 1'b0;
    logic                             o_in_stall;
    logic [PIX_BITS-1:0]              i_height_value = '0;
    logic                             o_out_valid;
    logic                             i_out_stall    = 1'b0;
    logic [rlms_pkg::SUM_W-1:0]       o_risk_sum;
    logic [rlms_pkg::COUNT_W-1:0]     o_low_count;
    logic                             i_cfg_we       = 1'b0;
    logic [rlms_pkg::CFG_INDEX_W-1:0] i_cfg_index    = '0;
    logic [rlms_pkg::CFG_DATA_W-1:0]  i_cfg_data     = '0;

    logic no_idle    = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    int cycle_count = 0;
    int fail_count  = 0;

    t_frame_total expected_totals[$];
    t_script_row  script [SCRIPT_LEN];

    // Predictor state: register copies, two line banks chosen by row parity,
    // raster position, last pixel and the running totals.
    logic [rlms_pkg::FW_W-1:0] model_width  = rlms_pkg::FRAME_WIDTH_RESET;
    logic [rlms_pkg::FH_W-1:0] model_height = rlms_pkg::FRAME_HEIGHT_RESET;
    logic [PIX_BITS-1:0] line_mem [2][LINE_DEPTH];
    int col_pos    = 0;
    int row_pos    = 0;
    int left_px    = 0;
    int risk_total = 0;
    int low_total  = 0;

    raster_local_minimum_sum #(
        .MAX_WIDTH  (LINE_DEPTH),
        .VALUE_BITS (PIX_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_height_value (i_height_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_risk_sum     (o_risk_sum),
        .o_low_count    (o_low_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        foreach (line_mem[b, i]) line_mem[b][i] = '0;
    end

    function automatic int eff_cols();
        if (model_width == 0) return 1;
        if (model_width > LINE_DEPTH) return LINE_DEPTH;
        return int'(model_width);
    endfunction

    function automatic int eff_rows();
        if (model_height == 0) return 1;
        if (model_height > rlms_pkg::HEIGHT_MAX) return int'(rlms_pkg::HEIGHT_MAX);
        return int'(model_height);
    endfunction

    function automatic int line_px(int bank, int idx);
        if (idx < 0 || idx >= LINE_DEPTH) return 0;
        return int'(line_mem[bank][idx]);
    endfunction

    // A missing neighbour never disqualifies the centre pixel.
    function automatic void score_if_minimum(int center,
                                             bit has_r, int rv, bit has_l, int lv,
                                             bit has_d, int dv, bit has_u, int uv);
        if (has_r && rv <= center) return;
        if (has_l && lv <= center) return;
        if (has_d && dv <= center) return;
        if (has_u && uv <= center) return;
        risk_total = risk_total + center + 1;
        if (risk_total > int'(rlms_pkg::SUM_MAX)) risk_total = int'(rlms_pkg::SUM_MAX);
        if (low_total < int'(rlms_pkg::COUNT_MAX)) low_total = low_total + 1;
    endfunction

    function automatic void predict_pixel(input logic [PIX_BITS-1:0] pix,
                                          output bit emit, output t_frame_total res);
        int  w, h, c, r, v, cb, ab;
        bit  last_col, last_row;
        w  = eff_cols();
        h  = eff_rows();
        c  = col_pos;
        r  = row_pos;
        v  = int'(pix);
        cb = r % 2;
        ab = 1 - cb;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        emit = 1'b0;
        res  = '0;

        // The pixel above now has its lower neighbour.
        if (r > 0)
            score_if_minimum(line_px(ab, c), c + 1 < w, line_px(ab, c + 1),
                             c > 0, line_px(ab, c - 1), 1'b1, v,
                             r > 1, line_px(cb, c));
        if (last_row) begin
            if (c > 0)
                score_if_minimum(line_px(cb, c - 1), 1'b1, v,
                                 c > 1, line_px(cb, c - 2), 1'b0, 0,
                                 r > 0, line_px(ab, c - 1));
            if (last_col)
                score_if_minimum(v, 1'b0, 0, c > 0, left_px, 1'b0, 0,
                                 r > 0, line_px(ab, c));
        end

        if (c < LINE_DEPTH) line_mem[cb][c] = pix;
        left_px = v;

        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                emit          = 1'b1;
                res.risk_sum  = risk_total[rlms_pkg::SUM_W-1:0];
                res.low_count = low_total[rlms_pkg::COUNT_W-1:0];
                risk_total    = 0;
                low_total     = 0;
                row_pos       = 0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic t_script_row reg_row(rlms_pkg::t_cfg_index sel,
                                            logic [rlms_pkg::CFG_DATA_W-1:0] d);
        return '{ROW_REG, sel, d, '0, 1'b0, '0};
    endfunction

    function automatic t_script_row pix_row(logic [PIX_BITS-1:0] v);
        return '{ROW_PIXEL, rlms_pkg::CFG_FRAME_WIDTH, '0, v, 1'b0, '0};
    endfunction

    function automatic t_script_row end_row(logic [PIX_BITS-1:0] v, int s, int n);
        t_frame_total t;
        t.risk_sum  = s[rlms_pkg::SUM_W-1:0];
        t.low_count = n[rlms_pkg::COUNT_W-1:0];
        return '{ROW_PIXEL, rlms_pkg::CFG_FRAME_WIDTH, '0, v, 1'b1, t};
    endfunction

    function automatic logic [PIX_BITS-1:0] draw_height(int mode);
        case (mode)
            0: return PIX_BITS'($urandom_range(0, 2));
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: return ($urandom_range(0, 5) == 0) ? PIX_BITS'($urandom_range(0, 3))
                                                 : PIX_BITS'($urandom_range(8, 15));
            default: return PIX_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    // Nothing in flight: no result owed and the pipeline given time to empty.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rlms_pkg::t_cfg_index sel,
                             input logic [rlms_pkg::CFG_DATA_W-1:0] val);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (sel == rlms_pkg::CFG_FRAME_WIDTH) model_width = val[rlms_pkg::FW_W-1:0];
        else model_height = val[rlms_pkg::FH_W-1:0];
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_BITS-1:0] v, input logic typed,
                              input t_frame_total typed_total);
        bit           emit;
        t_frame_total res;
        while (!no_idle && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_height_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_pixel(v, emit, res);
        if (typed) res = typed_total;
        if (emit) expected_totals.insert(expected_totals.size(), res);
    endtask

    // Receiver: random stalls, one long hold when asked, none in stretches without idle cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < 34);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_frame_total want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_totals.size() == 0) begin
                report_mismatch("result item with no frame pending");
            end else begin
                want = expected_totals.pop_front();
                if (o_risk_sum !== want.risk_sum)
                    report_mismatch($sformatf("risk_sum %0d, predicted %0d",
                                              o_risk_sum, want.risk_sum));
                if (o_low_count !== want.low_count)
                    report_mismatch($sformatf("low_count %0d, predicted %0d",
                                              o_low_count, want.low_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int                              sel, mode, frame_pixels, random_pixels;
        logic [rlms_pkg::CFG_DATA_W-1:0] wdata, hdata;

        script = '{
            reg_row(rlms_pkg::CFG_FRAME_WIDTH, 13'd1),
            reg_row(rlms_pkg::CFG_FRAME_HEIGHT, 13'd1),
            end_row(4'd0, 1, 1), end_row(4'd15, 16, 1),
            // Width bits above the register are dropped, so this is zero.
            reg_row(rlms_pkg::CFG_FRAME_WIDTH, 13'h100),
            reg_row(rlms_pkg::CFG_FRAME_HEIGHT, 13'd0),
            end_row(4'd9, 10, 1),
            reg_row(rlms_pkg::CFG_FRAME_WIDTH, 13'd2),
            pix_row(4'd3), end_row(4'd5, 4, 1),
            pix_row(4'd5), end_row(4'd5, 0, 0),
            reg_row(rlms_pkg::CFG_FRAME_WIDTH, 13'd3),
            reg_row(rlms_pkg::CFG_FRAME_HEIGHT, 13'd2),
            pix_row(4'd4), pix_row(4'd1), pix_row(4'd7),
            pix_row(4'd2), pix_row(4'd9), pix_row(4'd0),
            reg_row(rlms_pkg::CFG_FRAME_WIDTH, 13'd255),
            reg_row(rlms_pkg::CFG_FRAME_HEIGHT, 13'd8191),
            pix_row(4'd8), pix_row(4'd3), pix_row(4'd6),
            pix_row(4'd2), pix_row(4'd9), pix_row(4'd1),
            // Narrowing mid-row: column six is past the new bound and closes the row.
            reg_row(rlms_pkg::CFG_FRAME_WIDTH, 13'd4),
            pix_row(4'd5),
            // Row one is already at the new bound, so it is the last row.
            reg_row(rlms_pkg::CFG_FRAME_HEIGHT, 13'd1),
            pix_row(4'd4), pix_row(4'd2), pix_row(4'd0), pix_row(4'd11)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) write_reg(script[i].sel, script[i].data);
            else send_pixel(script[i].pix, script[i].typed, script[i].total);
        end

        // Single-pixel frames while the receiver holds off: the block fills up.
        write_reg(rlms_pkg::CFG_FRAME_WIDTH, 13'd1);
        write_reg(rlms_pkg::CFG_FRAME_HEIGHT, 13'd1);
        no_idle  <= 1'b1;
        hold_req <= 1'b1;
        repeat (40) send_pixel(PIX_BITS'($urandom), 1'b0, '0);
        random_pixels = 40;

        while (random_pixels < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                case ($urandom_range(0, 2))
                    0: wdata = 13'd128;
                    1: wdata = 13'd255;
                    default: wdata = rlms_pkg::CFG_DATA_W'($urandom_range(129, 255));
                endcase
                hdata = rlms_pkg::CFG_DATA_W'($urandom_range(1, 2));
            end else if (sel < 7) begin
                wdata = rlms_pkg::CFG_DATA_W'($urandom_range(0, 1));
                hdata = rlms_pkg::CFG_DATA_W'($urandom_range(10, 120));
            end else if (sel < 15) begin
                wdata = rlms_pkg::CFG_DATA_W'($urandom_range(1, 6));
                hdata = rlms_pkg::CFG_DATA_W'($urandom_range(0, 1));
            end else begin
                wdata = rlms_pkg::CFG_DATA_W'($urandom_range(1, 12));
                hdata = rlms_pkg::CFG_DATA_W'($urandom_range(1, 8));
            end
            if ($urandom_range(0, 3) == 0) wdata[12:8] = 5'($urandom_range(0, 31));

            no_idle <= (random_pixels >= 600 && random_pixels < 900);
            if ($urandom_range(0, 1)) begin
                write_reg(rlms_pkg::CFG_FRAME_WIDTH, wdata);
                write_reg(rlms_pkg::CFG_FRAME_HEIGHT, hdata);
            end else begin
                write_reg(rlms_pkg::CFG_FRAME_HEIGHT, hdata);
                write_reg(rlms_pkg::CFG_FRAME_WIDTH, wdata);
            end

            mode = $urandom_range(0, 4);
            frame_pixels = eff_cols() * eff_rows();
            repeat (frame_pixels) send_pixel(draw_height(mode), 1'b0, '0);
            random_pixels += frame_pixels;
        end

        no_idle <= 1'b0;
        settle_block();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/rlms_pkg.sv
sv/rlms_ram.sv
sv/rlms_cell.sv
sv/rlms_judge.sv
sv/raster_local_minimum_sum.sv
sv/rlms_checker.sv
bench/tb_raster_local_minimum_sum.sv
